### rtl/hcmb_pkg.sv
// ----------------------------------------------------------------------------
// hcmb_pkg
// Shared types and constants for the bucketed hash code map.
// ----------------------------------------------------------------------------
package hcmb_pkg;

  localparam int CODE_W   = 32;
  localparam int VALUE_W  = 32;
  localparam int FUNC_W   = 2;
  localparam int ECOUNT_W = 7;

  // Request codes
  localparam logic [FUNC_W-1:0] FUNC_PUT = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_GET = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_DEL = 2'd2;
  localparam logic [FUNC_W-1:0] FUNC_CLR = 2'd3;

  // Result status codes
  localparam logic STATUS_DONE = 1'b0;
  localparam logic STATUS_FULL = 1'b1;

  // Bucket index reduction: code bits consumed per step
  localparam int REM_BITS   = 8;
  localparam int REM_STEPS  = CODE_W / REM_BITS;
  localparam int REM_CNT_W  = $clog2(REM_STEPS);

  localparam logic [ECOUNT_W-1:0] ECOUNT_MAX = 7'd127;

  typedef struct packed {
    logic load;      // take the request in
    logic rem_step;  // advance the bucket index reduction
    logic mem_rd;    // read the bucket row
    logic sweep_wr;  // clear one bucket row
    logic finish;    // write back, update count and load the result
  } hcmb_cmd_t;

  typedef struct packed {
    logic is_clear;
    logic rem_last;
    logic sweep_last;
  } hcmb_sts_t;

endpackage

### rtl/hcmb_rem.sv
// ----------------------------------------------------------------------------
// hcmb_rem
// Reduces a 32-bit code modulo NUM_BUCKETS, REM_BITS (8) code bits per step (restoring
// remainder, most significant bit first).
// ----------------------------------------------------------------------------
module hcmb_rem #(
  parameter int NUM_BUCKETS = 16
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start,
  input  logic                               step,
  input  logic [hcmb_pkg::CODE_W-1:0]        code,
  output logic                               last,
  output logic [$clog2(NUM_BUCKETS)-1:0]     rem
);

  localparam int REM_W = $clog2(NUM_BUCKETS);
  localparam logic [REM_W:0] NB_T = (REM_W + 1)'(NUM_BUCKETS);

  logic [hcmb_pkg::CODE_W-1:0]  shift_r;
  logic [REM_W-1:0]             rem_r, rem_nxt;
  logic [hcmb_pkg::REM_CNT_W-1:0] cnt_r;
  logic [REM_W-1:0]             r;
  logic [REM_W:0]               t;

  always_comb begin
    r = rem_r;
    t = '0;
    for (int i = 0; i < hcmb_pkg::REM_BITS; i++) begin
      t = {r, shift_r[hcmb_pkg::CODE_W-1-i]};
      if (t >= NB_T) t = t - NB_T;
      r = t[REM_W-1:0];
    end
    rem_nxt = r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (start) begin
      cnt_r <= '0;
    end else if (step) begin
      cnt_r <= cnt_r + hcmb_pkg::REM_CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      shift_r <= code;
      rem_r   <= '0;
    end else if (step) begin
      shift_r <= shift_r << hcmb_pkg::REM_BITS;
      rem_r   <= rem_nxt;
    end
  end

  assign last = (cnt_r == hcmb_pkg::REM_CNT_W'(hcmb_pkg::REM_STEPS - 1));
  assign rem  = rem_r;

endmodule

### rtl/hcmb_dp.sv
// ----------------------------------------------------------------------------
// hcmb_dp
// Datapath: request registers, bucket index unit, bucket row memory,
// slot match and update, entry count and result register.
// ----------------------------------------------------------------------------
module hcmb_dp #(
  parameter int NUM_BUCKETS = 16,
  parameter int WAYS        = 4
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  hcmb_pkg::hcmb_cmd_t                 cmd,
  output hcmb_pkg::hcmb_sts_t                 sts,
  input  logic [hcmb_pkg::FUNC_W-1:0]         in_func,
  input  logic [hcmb_pkg::CODE_W-1:0]         in_key_code,
  input  logic [hcmb_pkg::VALUE_W-1:0]        in_put_value,
  output logic                                out_found,
  output logic [hcmb_pkg::VALUE_W-1:0]        out_read_value,
  output logic                                out_status,
  output logic [hcmb_pkg::ECOUNT_W-1:0]       out_entry_count
);

  localparam int REM_W   = $clog2(NUM_BUCKETS);
  localparam int TOTAL   = NUM_BUCKETS * WAYS;
  localparam int CNT_W   = $clog2(TOTAL + 1);
  localparam int EXT_W   = CNT_W + hcmb_pkg::ECOUNT_W;

  logic [hcmb_pkg::FUNC_W-1:0]  func_r;
  logic [hcmb_pkg::CODE_W-1:0]  code_r;
  logic [hcmb_pkg::VALUE_W-1:0] val_r;
  logic [REM_W-1:0]             bucket;
  logic                         rem_last;
  logic [REM_W-1:0]             sweep_r;
  logic [CNT_W-1:0]             count_r, count_nxt;
  logic [EXT_W-1:0]             count_ext;

  // bucket row memory
  logic [WAYS-1:0]                              vmem [NUM_BUCKETS];
  logic [WAYS-1:0][hcmb_pkg::CODE_W-1:0]        cmem [NUM_BUCKETS];
  logic [WAYS-1:0][hcmb_pkg::VALUE_W-1:0]       dmem [NUM_BUCKETS];
  logic [WAYS-1:0]                              rv_q;
  logic [WAYS-1:0][hcmb_pkg::CODE_W-1:0]        rc_q;
  logic [WAYS-1:0][hcmb_pkg::VALUE_W-1:0]       rd_q;

  logic [WAYS-1:0]                              new_v;
  logic [WAYS-1:0][hcmb_pkg::CODE_W-1:0]        new_c;
  logic [WAYS-1:0][hcmb_pkg::VALUE_W-1:0]       new_d;
  logic [WAYS-1:0]                              hit_oh, free_oh;
  logic                                         hit_any, free_any, hit_w;
  logic [hcmb_pkg::VALUE_W-1:0]                 rd_sel;

  logic                 mem_we;
  logic [REM_W-1:0]     waddr;
  logic                 found_nxt, status_nxt;
  logic [hcmb_pkg::VALUE_W-1:0] rdval_nxt;

  hcmb_rem #(
    .NUM_BUCKETS (NUM_BUCKETS)
  ) u_rem (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.load),
    .step  (cmd.rem_step),
    .code  (in_key_code),
    .last  (rem_last),
    .rem   (bucket)
  );

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      func_r <= in_func;
      code_r <= in_key_code;
      val_r  <= in_put_value;
    end
  end

  // row sweep counter, used for the pass after reset and for clear
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sweep_r <= '0;
    end else if (cmd.load) begin
      sweep_r <= '0;
    end else if (cmd.sweep_wr) begin
      sweep_r <= sts.sweep_last ? '0 : sweep_r + REM_W'(1);
    end
  end

  assign sts.is_clear   = (func_r == hcmb_pkg::FUNC_CLR);
  assign sts.rem_last   = rem_last;
  assign sts.sweep_last = (sweep_r == REM_W'(NUM_BUCKETS - 1));

  // slot match: lowest matching way and lowest free way
  always_comb begin
    hit_any  = 1'b0;
    free_any = 1'b0;
    hit_oh   = '0;
    free_oh  = '0;
    rd_sel   = '0;
    hit_w    = 1'b0;
    for (int w = 0; w < WAYS; w++) begin
      hit_w = rv_q[w] && (rc_q[w] == code_r);
      if (hit_w && !hit_any) hit_oh[w] = 1'b1;
      if (!rv_q[w] && !free_any) free_oh[w] = 1'b1;
      hit_any  = hit_any | hit_w;
      free_any = free_any | !rv_q[w];
    end
    for (int w = 0; w < WAYS; w++) begin
      if (hit_oh[w]) rd_sel = rd_sel | rd_q[w];
    end
  end

  always_comb begin
    new_v = rv_q;
    new_c = rc_q;
    new_d = rd_q;
    for (int w = 0; w < WAYS; w++) begin
      if (func_r == hcmb_pkg::FUNC_PUT) begin
        if (hit_oh[w]) begin
          new_d[w] = val_r;
        end else if (!hit_any && free_oh[w]) begin
          new_v[w] = 1'b1;
          new_c[w] = code_r;
          new_d[w] = val_r;
        end
      end else if (func_r == hcmb_pkg::FUNC_DEL && hit_oh[w]) begin
        new_v[w] = 1'b0;
      end
    end
  end

  always_comb begin
    count_nxt  = count_r;
    found_nxt  = 1'b0;
    rdval_nxt  = '0;
    status_nxt = hcmb_pkg::STATUS_DONE;
    case (func_r)
      hcmb_pkg::FUNC_PUT: begin
        found_nxt = hit_any;
        if (!hit_any) begin
          if (free_any) count_nxt = count_r + CNT_W'(1);
          else status_nxt = hcmb_pkg::STATUS_FULL;
        end
      end
      hcmb_pkg::FUNC_GET: begin
        found_nxt = hit_any;
        rdval_nxt = rd_sel;
      end
      hcmb_pkg::FUNC_DEL: begin
        found_nxt = hit_any;
        rdval_nxt = rd_sel;
        if (hit_any && count_r != '0) count_nxt = count_r - CNT_W'(1);
      end
      hcmb_pkg::FUNC_CLR: begin
        count_nxt = '0;
      end
      default: begin
        count_nxt = count_r;
      end
    endcase
  end

  assign count_ext = EXT_W'(count_nxt);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (cmd.finish) begin
      count_r <= count_nxt;
    end
  end

  assign mem_we = cmd.sweep_wr ||
                  (cmd.finish && (func_r inside {hcmb_pkg::FUNC_PUT, hcmb_pkg::FUNC_DEL}));
  assign waddr  = cmd.sweep_wr ? sweep_r : bucket;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      vmem[waddr] <= cmd.sweep_wr ? '0 : new_v;
      cmem[waddr] <= cmd.sweep_wr ? '0 : new_c;
      dmem[waddr] <= cmd.sweep_wr ? '0 : new_d;
    end
    if (cmd.mem_rd) begin
      rv_q <= vmem[bucket];
      rc_q <= cmem[bucket];
      rd_q <= dmem[bucket];
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      out_found       <= found_nxt;
      out_read_value  <= rdval_nxt;
      out_status      <= status_nxt;
      out_entry_count <= (count_ext > EXT_W'(hcmb_pkg::ECOUNT_MAX)) ?
                         hcmb_pkg::ECOUNT_MAX : count_ext[hcmb_pkg::ECOUNT_W-1:0];
    end
  end

endmodule

### rtl/hcmb_ctrl.sv
// ----------------------------------------------------------------------------
// hcmb_ctrl
// Controller: sequences the clearing pass, the bucket index reduction, the
// row read and the write-back, and owns the result valid flag.
// ----------------------------------------------------------------------------
module hcmb_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  output logic                 out_valid,
  input  logic                 out_ready,
  input  hcmb_pkg::hcmb_sts_t  sts,
  output hcmb_pkg::hcmb_cmd_t  cmd
);

  localparam logic [2:0] S_INIT = 3'd0;
  localparam logic [2:0] S_IDLE = 3'd1;
  localparam logic [2:0] S_MOD  = 3'd2;
  localparam logic [2:0] S_RD   = 3'd3;
  localparam logic [2:0] S_CLR  = 3'd4;
  localparam logic [2:0] S_FIN  = 3'd5;

  logic [2:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       out_free;

  assign out_free = !out_valid_r || out_ready;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      S_INIT: begin
        cmd.sweep_wr = 1'b1;
        if (sts.sweep_last) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_MOD;
        end
      end
      S_MOD: begin
        if (sts.is_clear) begin
          state_nxt = S_CLR;
        end else begin
          cmd.rem_step = 1'b1;
          if (sts.rem_last) state_nxt = S_RD;
        end
      end
      S_RD: begin
        cmd.mem_rd = 1'b1;
        state_nxt  = S_FIN;
      end
      S_CLR: begin
        cmd.sweep_wr = 1'b1;
        if (sts.sweep_last) state_nxt = S_FIN;
      end
      S_FIN: begin
        if (out_free) begin
          cmd.finish = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_INIT;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.finish) out_valid_nxt = 1'b1;
    else if (out_ready) out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_INIT;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule

### rtl/hash_code_map_bucketed.sv
// ----------------------------------------------------------------------------
// hash_code_map_bucketed
// Map from 32-bit hash codes to 32-bit values, NUM_BUCKETS buckets of WAYS
// slots, bucket = code mod NUM_BUCKETS. Put, get, delete and clear.
//
//   channel | direction | payload
//   in_     | request   | func, key_code, put_value
//   out_    | result    | found, read_value, status, entry_count
//
// Put, get, delete: one request at a time, accept to next accept (modulo
//   reduction at 8 code bits a cycle, one row read, then match and
//   write-back on the single-port bucket memory, then back to accepting).
// Clear: every bucket row is cleared, one bucket row cleared per cycle.
// After reset the row memory is swept, with in_ready low.
// A held result in the output register stalls only the write-back stage.
// ----------------------------------------------------------------------------
module hash_code_map_bucketed #(
  parameter int NUM_BUCKETS = 16,
  parameter int WAYS        = 4
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [hcmb_pkg::FUNC_W-1:0]         in_func,
  input  logic [hcmb_pkg::CODE_W-1:0]         in_key_code,
  input  logic [hcmb_pkg::VALUE_W-1:0]        in_put_value,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic                                out_found,
  output logic [hcmb_pkg::VALUE_W-1:0]        out_read_value,
  output logic                                out_status,
  output logic [hcmb_pkg::ECOUNT_W-1:0]       out_entry_count
);

  hcmb_pkg::hcmb_cmd_t cmd;
  hcmb_pkg::hcmb_sts_t sts;

  hcmb_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  hcmb_dp #(
    .NUM_BUCKETS (NUM_BUCKETS),
    .WAYS        (WAYS)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .sts             (sts),
    .in_func         (in_func),
    .in_key_code     (in_key_code),
    .in_put_value    (in_put_value),
    .out_found       (out_found),
    .out_read_value  (out_read_value),
    .out_status      (out_status),
    .out_entry_count (out_entry_count)
  );

endmodule

### rtl/hcmb_chk.sv
// ----------------------------------------------------------------------------
// hcmb_chk
// Port-level checks for the hash code map, bound to the top level.
// ----------------------------------------------------------------------------
module hcmb_chk (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  input  logic                          in_ready,
  input  logic                          out_valid,
  input  logic                          out_ready,
  input  logic                          out_found,
  input  logic [hcmb_pkg::VALUE_W-1:0]  out_read_value,
  input  logic                          out_status,
  input  logic [hcmb_pkg::ECOUNT_W-1:0] out_entry_count
);

  // a held result keeps its payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_read_value) &&
    $stable(out_entry_count) && $stable(out_found) && $stable(out_status))
    else $error("result changed while stalled");

  // the input is closed as the row sweep after reset begins
  a_init_closed: assert property (@(posedge clk)
    !rst_n |=> !in_ready)
    else $error("input open during reset sweep");

  // one transaction in flight at a time
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("second request taken while busy");

  // a refused put found nothing and reads back zero
  a_full_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status |-> !out_found && (out_read_value == '0))
    else $error("refused put carries a hit");

endmodule

bind hash_code_map_bucketed hcmb_chk u_hcmb_chk (.*);
